// ===== sv/rpa_pkg.sv =====
`timescale 1ns / 1ps
// Package for the relay PID autotuner: run states, op codes, sequencer states
// and fixed-point constants. No dependencies.
package rpa_pkg;

  // Field widths
  localparam int TEMP_W  = 16;
  localparam int TIME_W  = 32;
  localparam int GAIN_W  = 32;
  localparam int DRIVE_W = 8;
  localparam int CNT_W   = 4;

  // Crossing limits (defaults for the top-level parameters)
  localparam int MIN_CROSSINGS_DEF = 4;
  localparam int MAX_CROSSINGS_DEF = 10;

  // Peak trackers start at +/-1000.0 in Q11.4
  localparam logic signed [TEMP_W-1:0] PEAK_INIT = 16'sd16000;
  // Swing must exceed 1.0 (Q11.4)
  localparam logic signed [TEMP_W:0]   SWING_MIN = 17'sd16;

  // 5 * round(pi * 2^28): scales the swing into the Kp divisor
  localparam logic [31:0] K_DEN    = 32'd4216574285;
  // Kp numerator factor 384, shifted left by 44
  localparam logic [8:0]  KP_NUM   = 9'd384;
  localparam int          KP_SHIFT = 44;
  localparam logic [31:0] KI_MUL   = 32'd1000;
  localparam logic [GAIN_W-1:0] GAIN_SAT = '1;

  // Kd = x / 4000 = (x >> 5) / 125: reciprocal floor(2^39 / 125) - 2^32,
  // saturation bound 4000 * 2^32, and the correction thresholds
  localparam logic [31:0] KD_RCP   = 32'd103079215;
  localparam logic [63:0] KD_SAT   = 64'd17179869184000;
  localparam logic [8:0]  KD_Q5    = 9'd125;
  localparam logic [8:0]  KD_Q5X2  = 9'd250;

  // Divider geometry
  localparam int DVD_W  = 64;
  localparam int DIVR_W = 48;
  localparam int STEP_W = 6;

  typedef enum logic [1:0] {
    RUN_IDLE     = 2'd0,
    RUN_TUNING   = 2'd1,
    RUN_COMPLETE = 2'd2,
    RUN_FAILED   = 2'd3
  } run_e;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_START  = 2'd1,
    OP_STOP   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_SETPOINT = 2'd0,
    CFG_BASE     = 2'd1,
    CFG_STEP     = 2'd2,
    CFG_UNUSED   = 2'd3
  } cfg_e;

  typedef enum logic [3:0] {
    SEQ_IDLE   = 4'd0,
    SEQ_PREP_P = 4'd1,
    SEQ_DIV_P  = 4'd2,
    SEQ_PREP_I = 4'd3,
    SEQ_DIV_I  = 4'd4,
    SEQ_PREP_D = 4'd5,
    SEQ_RCP_D  = 4'd6,
    SEQ_FIX_D  = 4'd7,
    SEQ_OUT    = 4'd8
  } seq_e;

endpackage

// ===== sv/relay_pid_autotuner.sv =====
`timescale 1ns / 1ps
// Relay autotuner top level: relay drive, peak and crossing tracking, and a
// shared multiplier plus bit-serial divider for Ziegler-Nichols gains. Uses rpa_pkg.

// A sample, start, stop or unused-op beat yields its result beat in the cycle after
// acceptance. A sample that completes tuning runs the gain sequencer: a shared
// 32x32 multiplier feeds a 64-step restoring divider, one quotient bit per
// cycle, for Kp and then Ki; Kd comes from a reciprocal multiply and a small
// correction; with a zero measured period the Ki and Kd stages are skipped. The
// input is not ready until the gain sequencer has returned to idle. Results
// sit in an output register; the next beat is taken when no result waits or in
// the cycle in which the waiting result leaves.
module relay_pid_autotuner
  import rpa_pkg::*;
#(
  parameter int MIN_CROSSINGS = MIN_CROSSINGS_DEF,
  parameter int MAX_CROSSINGS = MAX_CROSSINGS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration write channel
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i,
  // Input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,   // temperature[15:0], now_ms[47:16]
  input  logic [1:0]   s_axis_tuser,   // op[1:0]
  // Result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [111:0] m_axis_tdata    // drive[7:0], tune_status[9:8], kp_gain[41:10],
                                       // ki_gain[73:42], kd_gain[105:74], zero[111:106]
);

  // Configuration registers
  logic signed [TEMP_W-1:0] setpoint_q;
  logic [DRIVE_W-1:0]       base_q, step_q;

  // Tuner state
  run_e                     run_q, run_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [TIME_W-1:0]        last_q, last_d;
  logic signed [TEMP_W-1:0] phigh_q, phigh_d, plow_q, plow_d;
  logic                     above_q, above_d;
  logic [GAIN_W-1:0]        gp_q, gi_q, gd_q;

  // Gain job operands
  logic [TEMP_W-1:0]        swing_q, swing_d;
  logic [TIME_W-1:0]        dt_q, dt_d;
  logic [DRIVE_W-1:0]       drv_q, drv_d;

  // Sequencer and divider
  seq_e                     seq_q, seq_d;
  logic [DVD_W-1:0]         dvd_q;
  logic [DIVR_W-1:0]        div_q, rem_q;
  logic [STEP_W-1:0]        step_cnt_q;
  logic [GAIN_W-1:0]        q0_q;

  // Output register
  logic                     mv_q;
  logic [111:0]             mdata_q;

  // Input beat fields
  op_e                      op;
  logic signed [TEMP_W-1:0] temp;
  logic [TIME_W-1:0]        now;
  logic                     in_fire, out_free, start_gain;

  assign op   = op_e'(s_axis_tuser);
  assign temp = s_axis_tdata[15:0];
  assign now  = s_axis_tdata[47:16];

  assign cfg_ready_o   = 1'b1;
  assign out_free      = !mv_q || m_axis_tready;
  assign s_axis_tready = (seq_q == SEQ_IDLE) && out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = mdata_q;

  // Per-beat tuner update
  logic [DRIVE_W:0]         d_sum;
  logic [DRIVE_W:0]         d_dif;
  logic [CNT_W:0]           next_cnt;
  logic signed [TEMP_W:0]   swing;
  logic                     above;
  always_comb begin
    run_d      = run_q;
    cnt_d      = cnt_q;
    last_d     = last_q;
    phigh_d    = phigh_q;
    plow_d     = plow_q;
    above_d    = above_q;
    drv_d      = base_q;
    swing_d    = swing_q;
    dt_d       = dt_q;
    start_gain = 1'b0;
    d_sum      = {1'b0, base_q} + {1'b0, step_q};
    d_dif      = {1'b0, base_q} - {1'b0, step_q};
    next_cnt   = {1'b0, cnt_q} + 1'b1;
    above      = temp > setpoint_q;
    swing      = '0;
    case (op)
      OP_START: begin
        run_d   = RUN_TUNING;
        cnt_d   = '0;
        last_d  = now;
        phigh_d = -PEAK_INIT;
        plow_d  = PEAK_INIT;
      end
      OP_STOP: run_d = RUN_IDLE;
      OP_SAMPLE: begin
        if (run_q == RUN_TUNING) begin
          if (temp < setpoint_q) drv_d = d_sum[DRIVE_W] ? '1 : d_sum[DRIVE_W-1:0];
          else drv_d = d_dif[DRIVE_W] ? '0 : d_dif[DRIVE_W-1:0];
          if (temp > phigh_q) phigh_d = temp;
          if (temp < plow_q) plow_d = temp;
          swing = {phigh_d[TEMP_W-1], phigh_d} - {plow_d[TEMP_W-1], plow_d};
          if (above != above_q) begin
            cnt_d   = next_cnt[CNT_W] ? '1 : next_cnt[CNT_W-1:0];
            dt_d    = now - last_q;
            last_d  = now;
            above_d = above;
            if (32'(next_cnt) >= MIN_CROSSINGS) begin
              if (swing > SWING_MIN) begin
                run_d      = RUN_COMPLETE;
                swing_d    = swing[TEMP_W-1:0];
                start_gain = 1'b1;
              end else if (32'(next_cnt) > MAX_CROSSINGS) begin
                run_d = RUN_FAILED;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Shared multiplier, operands chosen by the sequencer
  logic [31:0]       mul_a, mul_b;
  logic [63:0]       mul_p;
  always_comb begin
    mul_a = gp_q;
    mul_b = dt_q;
    unique case (seq_q)
      SEQ_PREP_P: begin
        mul_a = K_DEN;
        mul_b = {16'd0, swing_q};
      end
      SEQ_PREP_I: mul_b = KI_MUL;
      SEQ_RCP_D: begin
        mul_a = dvd_q[43:12];
        mul_b = KD_RCP;
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // One restoring-division step
  logic [DIVR_W:0]    rem_sh;
  logic               ge;
  logic [DIVR_W-1:0]  rem_nx;
  logic [DVD_W-1:0]   quo;
  logic [GAIN_W-1:0]  quo_sat;
  logic               last_step;
  assign rem_sh    = {rem_q, dvd_q[DVD_W-1]};
  assign ge        = rem_sh >= {1'b0, div_q};
  assign rem_nx    = ge ? DIVR_W'(rem_sh - {1'b0, div_q}) : rem_sh[DIVR_W-1:0];
  assign quo       = {dvd_q[DVD_W-2:0], ge};
  assign quo_sat   = (|quo[DVD_W-1:GAIN_W]) ? GAIN_SAT : quo[GAIN_W-1:0];
  assign last_step = &step_cnt_q;

  // Kd: estimate from the reciprocal is at most two low; the low remainder
  // bits pick the correction
  logic [8:0]        kd_rem;
  logic              kd_sat;
  logic [GAIN_W-1:0] kd_val;
  assign kd_rem = dvd_q[13:5] - 9'(q0_q[8:0] * KD_Q5);
  assign kd_sat = dvd_q >= KD_SAT;
  assign kd_val = kd_sat ? GAIN_SAT
                : q0_q + GAIN_W'({kd_rem >= KD_Q5X2, (kd_rem >= KD_Q5) && (kd_rem < KD_Q5X2)});

  // Sequencer next state
  always_comb begin
    seq_d = seq_q;
    unique case (seq_q)
      SEQ_IDLE:   if (in_fire && start_gain) seq_d = SEQ_PREP_P;
      SEQ_PREP_P: seq_d = SEQ_DIV_P;
      SEQ_DIV_P:  if (last_step) seq_d = (dt_q == '0) ? SEQ_OUT : SEQ_PREP_I;
      SEQ_PREP_I: seq_d = SEQ_DIV_I;
      SEQ_DIV_I:  if (last_step) seq_d = SEQ_PREP_D;
      SEQ_PREP_D: seq_d = SEQ_RCP_D;
      SEQ_RCP_D:  seq_d = SEQ_FIX_D;
      SEQ_FIX_D:  seq_d = SEQ_OUT;
      SEQ_OUT:    if (out_free) seq_d = SEQ_IDLE;
      default:    seq_d = SEQ_IDLE;
    endcase
  end

  // Divider load values per preparation state
  logic              div_load;
  logic [DVD_W-1:0]  dvd_ld;
  logic [DIVR_W-1:0] div_ld;
  always_comb begin
    div_load = 1'b0;
    dvd_ld   = mul_p;
    div_ld   = {16'd0, dt_q};
    unique case (seq_q)
      SEQ_PREP_P: begin
        div_load = 1'b1;
        dvd_ld   = DVD_W'({8'd0, step_q} * {8'd0, KP_NUM}) << KP_SHIFT;
        div_ld   = mul_p[DIVR_W-1:0];
      end
      SEQ_PREP_I: div_load = 1'b1;
      // Kp * dt is held for the Kd stages
      SEQ_PREP_D: div_load = 1'b1;
      default: ;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q <= '0;
      base_q     <= '0;
      step_q     <= 8'd20;
    end else if (cfg_valid_i) begin
      unique case (cfg_e'(cfg_index_i))
        CFG_SETPOINT: setpoint_q <= cfg_data_i;
        CFG_BASE:     base_q     <= cfg_data_i[7:0];
        CFG_STEP:     step_q     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Tuner state, sequencer state and gains
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= RUN_IDLE;
      cnt_q   <= '0;
      last_q  <= '0;
      phigh_q <= -PEAK_INIT;
      plow_q  <= PEAK_INIT;
      above_q <= 1'b0;
      gp_q    <= '0;
      gi_q    <= '0;
      gd_q    <= '0;
      seq_q   <= SEQ_IDLE;
    end else begin
      seq_q <= seq_d;
      if (in_fire) begin
        run_q   <= run_d;
        cnt_q   <= cnt_d;
        last_q  <= last_d;
        phigh_q <= phigh_d;
        plow_q  <= plow_d;
        above_q <= above_d;
      end
      if (last_step) begin
        unique case (seq_q)
          SEQ_DIV_P: begin
            gp_q <= quo_sat;
            if (dt_q == '0) begin
              gi_q <= (quo_sat != '0) ? GAIN_SAT : '0;
              gd_q <= '0;
            end
          end
          SEQ_DIV_I: gi_q <= quo_sat;
          default: ;
        endcase
      end
      if (seq_q == SEQ_FIX_D) gd_q <= kd_val;
    end
  end

  // Job operands and divider datapath
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      swing_q <= swing_d;
      dt_q    <= dt_d;
      drv_q   <= drv_d;
    end
    if (div_load) begin
      dvd_q      <= dvd_ld;
      div_q      <= div_ld;
      rem_q      <= '0;
      step_cnt_q <= '0;
    end else if (seq_q == SEQ_DIV_P || seq_q == SEQ_DIV_I) begin
      dvd_q      <= quo;
      rem_q      <= rem_nx;
      step_cnt_q <= step_cnt_q + 1'b1;
    end
    if (seq_q == SEQ_RCP_D) q0_q <= dvd_q[43:12] + mul_p[63:32];
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else if (in_fire && !start_gain) begin
      mv_q <= 1'b1;
    end else if (seq_q == SEQ_OUT && out_free) begin
      mv_q <= 1'b1;
    end else if (m_axis_tready) begin
      mv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && !start_gain) begin
      mdata_q <= {6'd0, gd_q, gi_q, gp_q, run_d, drv_d};
    end else if (seq_q == SEQ_OUT && out_free) begin
      mdata_q <= {6'd0, gd_q, gi_q, gp_q, run_q, drv_q};
    end
  end

  // Checks
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> seq_q == SEQ_IDLE)
    else $error("input ready while gain sequencer busy");

  a_busy_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_q != SEQ_IDLE |-> run_q == RUN_COMPLETE)
    else $error("gain sequencer running outside completion");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SEQ_DIV_P || seq_q == SEQ_DIV_I) |-> rem_q < div_q)
    else $error("divider remainder not below divisor");

  a_job_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_q == SEQ_PREP_P |-> $past(in_fire) && !$past(mv_q && !m_axis_tready))
    else $error("gain job started without an accepted beat");

endmodule
